// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, also active during reset.
`define RFT_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("rft assertion failed");

// Clocked assertion, off while reset is asserted (active low).
`define RFT_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rft assertion failed");

`endif

// ===== rtl/rft_pkg.sv =====
// Shared types, widths and constant functions of the real-input FFT unit.
// No dependencies.
package rft_pkg;

  localparam int SMP_W  = 16;  // input sample, Q1.15
  localparam int BIN_W  = 24;  // bin component
  localparam int CFG_W  = 3;   // size_log2 register
  localparam int COS_W  = 18;  // signed Q2.16 twiddle
  localparam int PROD_W = 42;  // BIN_W x COS_W product
  localparam int RSUM_W = 43;  // sum of two products
  localparam int PP_W   = 27;  // rounded product, Q.15
  localparam int BSUM_W = 28;  // E +/- P before clamp
  localparam int ENT_W  = 2 * BIN_W;

  localparam logic [CFG_W-1:0] SIZE_RESET = 3'd6;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_E,
    ST_RD_O,
    ST_CAP_O,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_WR_E,
    ST_WR_O,
    ST_OUT_RD,
    ST_OUT_CAP
  } state_t;

  typedef enum logic [1:0] {
    MUL_ORE_C,
    MUL_OIM_S,
    MUL_OIM_C,
    MUL_ORE_S
  } mul_sel_t;

  typedef struct packed {
    logic     e_load;
    logic     o_load;
    mul_sel_t mul_sel;
    logic     p_load;
    logic     acc_load;
    logic     pr_load;
    logic     pi_load;
  } bfly_ctl_t;

  // floor of num / den by shift and subtract, for the ROM series
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos of an angle in [0, pi/2] in Q30, Taylor series, result in Q30
  function automatic longint unsigned cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sm;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sm   = longint'(ONE_Q30);
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * i - 1) * (2 * i)));
      if ((i % 2) == 1) sm = sm - longint'(term);
      else              sm = sm + longint'(term);
    end
    if (sm < 0) sm = 0;
    if (sm > longint'(ONE_Q30)) sm = longint'(ONE_Q30);
    return longint'(sm);
  endfunction

  // ROM entry in Q2.16 (always non-negative) from an angle in Q30
  function automatic logic [COS_W-2:0] cos_entry(input longint unsigned th);
    longint unsigned c;
    c = cos_q30(th);
    return (COS_W - 1)'((c + 64'd8192) >> 14);
  endfunction

  function automatic logic signed [BIN_W-1:0] sat24(input logic signed [BSUM_W-1:0] v);
    logic signed [BSUM_W-1:0] hi;
    logic signed [BSUM_W-1:0] lo;
    hi = BSUM_W'(8388607);
    lo = -BSUM_W'(8388608);
    if (v > hi)      return BIN_W'(hi);
    else if (v < lo) return BIN_W'(lo);
    else             return BIN_W'(v);
  endfunction

endpackage

// ===== rtl/rft_if.sv =====
// Valid/ready channel interfaces: sample in, bins out, size config.
// Depends on rft_pkg.
interface rft_in_if import rft_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rft_out_if import rft_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [BIN_W-1:0] bin_real;
  logic signed [BIN_W-1:0] bin_imag;
  logic                    last;
  modport source (output valid, output bin_real, output bin_imag, output last,
                  input ready);
  modport sink   (input valid, input bin_real, input bin_imag, input last,
                  output ready);
endinterface

interface rft_cfg_if import rft_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] size_log2;
  modport source (output valid, output size_log2, input ready);
  modport sink   (input valid, input size_log2, output ready);
endinterface

// ===== rtl/radix2_fft_real_input_unit.sv =====
// Real-input radix-2 DIT FFT unit: sequencer, working store and top ports.
// Depends on rft_pkg, rft_if, rft_ram, rft_twiddle and rft_bfly.
//
// Takes N = 2^min(size_log2, log2(MAX_POINTS)) real Q1.15 samples, one per
// beat, then returns the N complex bins in order with last on bin N-1. The
// frame's last sample starts the transform and in_ready stays low until the
// final bin sits in the output register. Each butterfly runs on the single
// multiplier and the working store (one write port, one read port) in the
// steps read E, read O, capture O, five multiply/round steps, write E and
// write O. Each bin is read from the store and then captured in the output
// register; a read waits while a stalled bin holds that register. Writing
// size_log2 drops a partial frame. MAX_POINTS must be a power of two.
module radix2_fft_real_input_unit import rft_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  rft_cfg_if.sink   cfg_ch,
  rft_in_if.sink    in_ch,
  rft_out_if.source out_ch
);

  localparam int LOG2M  = $clog2(MAX_POINTS);
  localparam int ADDR_W = LOG2M;              // store address, butterfly index
  localparam int AW     = LOG2M + 1;          // twiddle angle
  localparam int CW     = LOG2M + 1;          // load count, holds N
  localparam int LGW    = $clog2(LOG2M + 1);  // size / stage

  // ---------------- registers
  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  size_r;
  logic [CW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [LGW-1:0]    stg_r, stg_nxt;          // butterfly stage
  logic [ADDR_W-1:0] bf_r, bf_nxt;            // butterfly within stage
  logic [ADDR_W-1:0] bin_r, bin_nxt;          // bin being read out
  logic              out_valid_r, out_valid_nxt;
  logic [ENT_W-1:0]  out_data_r;
  logic              out_last_r;
  logic              out_load;

  // ---------------- size decode
  logic [LGW-1:0]    lg;
  logic [CW-1:0]     n_pts;
  logic [ADDR_W-1:0] n_m1;
  logic [ADDR_W-1:0] half_m1;

  always_comb begin
    lg      = (int'(size_r) > LOG2M) ? LGW'(LOG2M) : LGW'(size_r);
    n_pts   = CW'(1) << lg;
    n_m1    = ADDR_W'(n_pts - CW'(1));
    half_m1 = ADDR_W'((n_pts >> 1) - CW'(1));
  end

  // ---------------- load address: bit reverse over lg bits
  logic [ADDR_W-1:0] rev;
  logic [ADDR_W-1:0] load_pos;

  always_comb begin
    for (int b = 0; b < ADDR_W; b++) begin
      rev[b] = load_cnt_r[ADDR_W-1-b];
    end
    load_pos = rev >> (LGW'(LOG2M) - lg);
  end

  // ---------------- butterfly addresses and twiddle angle
  logic [ADDR_W-1:0] bf_hi, bf_lo, idx_e, idx_o;
  logic [AW-1:0]     tw_a;

  always_comb begin
    bf_hi = ((bf_r >> stg_r) << 1) << stg_r;
    bf_lo = bf_r & ((ADDR_W'(1) << stg_r) - ADDR_W'(1));
    idx_e = bf_hi | bf_lo;
    idx_o = idx_e | (ADDR_W'(1) << stg_r);
    // k * (2*MAX_POINTS / h)
    tw_a  = AW'({bf_lo, 1'b0} << (LGW'(LOG2M) - stg_r));
  end

  // ---------------- datapath instances
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [ENT_W-1:0]        ram_wdata, ram_rdata;
  logic                    tw_load;
  logic signed [COS_W-1:0] tw_c, tw_s;
  bfly_ctl_t               bctl;
  logic [ENT_W-1:0]        bf_sum, bf_dif;

  rft_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rft_twiddle #(
    .MAX_POINTS (MAX_POINTS)
  ) u_twiddle (
    .clk  (clk),
    .load (tw_load),
    .a    (tw_a),
    .c_r  (tw_c),
    .s_r  (tw_s)
  );

  rft_bfly u_bfly (
    .clk     (clk),
    .ctl     (bctl),
    .rdata   (ram_rdata),
    .c       (tw_c),
    .s       (tw_s),
    .sum_out (bf_sum),
    .dif_out (bf_dif)
  );

  // ---------------- handshakes
  logic in_acc, out_acc, cfg_acc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_acc      = out_valid_r & out_ch.ready;
  assign cfg_acc      = cfg_ch.valid;

  // ---------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    stg_nxt       = stg_r;
    bf_nxt        = bf_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r & ~out_acc;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_e;
    ram_wdata     = bf_sum;
    ram_raddr     = idx_e;
    tw_load       = 1'b0;
    bctl          = '{e_load: 1'b0, o_load: 1'b0, mul_sel: MUL_ORE_C, p_load: 1'b0,
                      acc_load: 1'b0, pr_load: 1'b0, pi_load: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ram_we    = 1'b1;
          ram_waddr = load_pos;
          ram_wdata = {{(BIN_W - SMP_W){in_ch.sample[SMP_W-1]}}, in_ch.sample,
                       {BIN_W{1'b0}}};
          stg_nxt   = '0;
          bf_nxt    = '0;
          bin_nxt   = '0;
          if (load_cnt_r == n_pts - CW'(1)) begin
            load_cnt_nxt = '0;
            // a one-point frame has no butterflies
            state_nxt    = (lg == '0) ? ST_OUT_RD : ST_RD_E;
          end else begin
            load_cnt_nxt = load_cnt_r + CW'(1);
          end
        end
      end
      ST_RD_E: begin
        ram_raddr = idx_e;
        tw_load   = 1'b1;
        state_nxt = ST_RD_O;
      end
      ST_RD_O: begin
        ram_raddr   = idx_o;
        bctl.e_load = 1'b1;
        state_nxt   = ST_CAP_O;
      end
      ST_CAP_O: begin
        bctl.o_load = 1'b1;
        state_nxt   = ST_MUL0;
      end
      ST_MUL0: begin
        bctl.mul_sel = MUL_ORE_C;
        bctl.p_load  = 1'b1;
        state_nxt    = ST_MUL1;
      end
      ST_MUL1: begin
        bctl.mul_sel  = MUL_OIM_S;
        bctl.p_load   = 1'b1;
        bctl.acc_load = 1'b1;
        state_nxt     = ST_MUL2;
      end
      ST_MUL2: begin
        bctl.mul_sel = MUL_OIM_C;
        bctl.p_load  = 1'b1;
        bctl.pr_load = 1'b1;
        state_nxt    = ST_MUL3;
      end
      ST_MUL3: begin
        bctl.mul_sel  = MUL_ORE_S;
        bctl.p_load   = 1'b1;
        bctl.acc_load = 1'b1;
        state_nxt     = ST_MUL4;
      end
      ST_MUL4: begin
        bctl.pi_load = 1'b1;
        state_nxt    = ST_WR_E;
      end
      ST_WR_E: begin
        ram_we    = 1'b1;
        ram_waddr = idx_e;
        ram_wdata = bf_sum;
        state_nxt = ST_WR_O;
      end
      ST_WR_O: begin
        ram_we    = 1'b1;
        ram_waddr = idx_o;
        ram_wdata = bf_dif;
        state_nxt = ST_RD_E;
        if (bf_r == half_m1) begin
          bf_nxt = '0;
          if (stg_r == lg - LGW'(1)) begin
            bin_nxt   = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            stg_nxt = stg_r + LGW'(1);
          end
        end else begin
          bf_nxt = bf_r + ADDR_W'(1);
        end
      end
      ST_OUT_RD: begin
        ram_raddr = bin_r;
        // read only once the output register will be free
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_OUT_CAP;
        end
      end
      ST_OUT_CAP: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        if (bin_r == n_m1) begin
          state_nxt = ST_IDLE;
        end else begin
          bin_nxt   = bin_r + ADDR_W'(1);
          state_nxt = ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // size change drops any partial frame
    if (cfg_acc) begin
      load_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      load_cnt_r  <= '0;
      stg_r       <= '0;
      bf_r        <= '0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      stg_r       <= stg_nxt;
      bf_r        <= bf_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        size_r <= cfg_ch.size_log2;
      end
    end
  end

  // output register: payload needs no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= ram_rdata;
      out_last_r <= (bin_r == n_m1);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.bin_real = out_data_r[ENT_W-1:BIN_W];
  assign out_ch.bin_imag = out_data_r[BIN_W-1:0];
  assign out_ch.last     = out_last_r;

endmodule

// ===== rtl/rft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rft_twiddle.sv =====
// Twiddle lookup: quarter-wave cos ROM in Q2.16, registered cos/sin out.
// Depends on rft_pkg.
module rft_twiddle import rft_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic [$clog2(MAX_POINTS):0]     a,
  output logic signed [COS_W-1:0]         c_r,
  output logic signed [COS_W-1:0]         s_r
);

  localparam int AW = $clog2(MAX_POINTS) + 1;
  localparam logic [AW:0] TWO_M = (AW + 1)'(2 * MAX_POINTS);

  logic [COS_W-2:0] rom [MAX_POINTS + 1];

  for (genvar gi = 0; gi <= MAX_POINTS; gi++) begin : g_rom
    localparam longint unsigned TH =
      (PI_Q30 * longint'(gi) + longint'(MAX_POINTS)) / longint'(2 * MAX_POINTS);
    assign rom[gi] = cos_entry(TH);
  end

  logic [AW-1:0]          c_idx;
  logic [AW-1:0]          s_idx;
  logic                   c_neg;
  logic signed [COS_W-1:0] c_nxt;
  logic signed [COS_W-1:0] s_nxt;

  always_comb begin
    if (a <= AW'(MAX_POINTS)) begin
      c_idx = a;
      s_idx = AW'(MAX_POINTS) - a;
      c_neg = 1'b0;
    end else begin
      c_idx = AW'(TWO_M - {1'b0, a});
      s_idx = a - AW'(MAX_POINTS);
      c_neg = 1'b1;
    end
    c_nxt = c_neg ? -signed'({1'b0, rom[c_idx]}) : signed'({1'b0, rom[c_idx]});
    s_nxt = signed'({1'b0, rom[s_idx]});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
    end
  end

endmodule

// ===== rtl/rft_bfly.sv =====
// Butterfly datapath: one shared multiplier, rounding and clamped E +/- P.
// Depends on rft_pkg.
module rft_bfly import rft_pkg::*; (
  input  logic                    clk,
  input  bfly_ctl_t               ctl,
  input  logic [ENT_W-1:0]        rdata,
  input  logic signed [COS_W-1:0] c,
  input  logic signed [COS_W-1:0] s,
  output logic [ENT_W-1:0]        sum_out,
  output logic [ENT_W-1:0]        dif_out
);

  logic signed [BIN_W-1:0]  e_re_r, e_im_r, o_re_r, o_im_r;
  logic signed [PROD_W-1:0] p_r, acc_r;
  logic signed [PP_W-1:0]   pr_r, pi_r;

  logic signed [BIN_W-1:0]  mul_a;
  logic signed [COS_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [RSUM_W-1:0] rsum;
  logic signed [RSUM_W-1:0] rsh;

  always_comb begin
    case (ctl.mul_sel)
      MUL_ORE_C: begin mul_a = o_re_r; mul_b = c; end
      MUL_OIM_S: begin mul_a = o_im_r; mul_b = s; end
      MUL_OIM_C: begin mul_a = o_im_r; mul_b = c; end
      MUL_ORE_S: begin mul_a = o_re_r; mul_b = s; end
      default:   begin mul_a = o_re_r; mul_b = c; end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    // real part adds, imaginary part subtracts
    rsum = ctl.pi_load ? (RSUM_W'(acc_r) - RSUM_W'(p_r))
                       : (RSUM_W'(acc_r) + RSUM_W'(p_r));
    rsh  = (rsum + RSUM_W'(32768)) >>> 16;  // nearest, half up
  end

  always_ff @(posedge clk) begin
    if (ctl.e_load) begin
      e_re_r <= rdata[ENT_W-1:BIN_W];
      e_im_r <= rdata[BIN_W-1:0];
    end
    if (ctl.o_load) begin
      o_re_r <= rdata[ENT_W-1:BIN_W];
      o_im_r <= rdata[BIN_W-1:0];
    end
    if (ctl.p_load)   p_r   <= prod;
    if (ctl.acc_load) acc_r <= p_r;
    if (ctl.pr_load)  pr_r  <= PP_W'(rsh);
    if (ctl.pi_load)  pi_r  <= PP_W'(rsh);
  end

  always_comb begin
    sum_out = {sat24(BSUM_W'(e_re_r) + BSUM_W'(pr_r)),
               sat24(BSUM_W'(e_im_r) + BSUM_W'(pi_r))};
    dif_out = {sat24(BSUM_W'(e_re_r) - BSUM_W'(pr_r)),
               sat24(BSUM_W'(e_im_r) - BSUM_W'(pi_r))};
  end

endmodule

// ===== rtl/rft_checker.sv =====
// Port-level checker for the real-input FFT unit, bound to the top level.
// Depends on rft_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rft_checker import rft_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_last,
  input logic signed [BIN_W-1:0] out_bin_real,
  input logic signed [BIN_W-1:0] out_bin_imag
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid & in_ready;
  assign out_beat = out_valid & out_ready;

  // stalled result keeps valid
  `RFT_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // stalled result keeps its bits
  `RFT_ASSERT_RST(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_bin_real) && $stable(out_bin_imag) && $stable(out_last))
  // mid-frame readout blocks new samples
  `RFT_ASSERT_RST(a_no_sample_mid_readout, clk, rst_n, out_beat && !out_last |=> !in_ready && !in_beat)
  // reset leaves the unit idle and empty
  `RFT_ASSERT(a_reset_idle, clk, !rst_n |=> in_ready && !out_valid)

endmodule

bind radix2_fft_real_input_unit rft_checker u_rft_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_last     (out_ch.last),
  .out_bin_real (out_ch.bin_real),
  .out_bin_imag (out_ch.bin_imag)
);

// ===== bench/radix2_fft_real_input_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for radix2_fft_real_input_unit: sample, bin and size beats.
// Depends on rft_pkg, the rft_if interfaces and the unit itself; no other files.
module radix2_fft_real_input_unit_test;
  import rft_pkg::*;

  localparam int NPTS      = 64;      // MAX_POINTS of the instance
  localparam int NLOG      = 6;
  localparam int DRAIN_GAP = 20;      // quiet cycles after the last bin
  localparam int WDOG_MAX  = 20000;   // quiet-cycle limit: a whole transform plus long stalls
  localparam int RAND_ITEMS = 100;

  typedef struct {
    int  re;
    int  im;
    bit  last;
  } bin_t;

  // one row of the directed table: either a size write or a sample beat
  typedef struct {
    bit                      is_cfg;
    logic [CFG_W-1:0]        size;
    logic signed [SMP_W-1:0] smp;
    bit                      typed;   // expected bin written in by hand
    int                      re;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rft_in_if  in_ch ();
  rft_out_if out_ch ();
  rft_cfg_if cfg_ch ();

  radix2_fft_real_input_unit #(.MAX_POINTS(NPTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch.sink),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Transform predictor: own copy of the twiddle ROM, working store,
  // frame position and size register.
  // ---------------------------------------------------------------------
  int   cos_tab [0:NPTS];
  int   wk_re [NPTS];
  int   wk_im [NPTS];
  int   frame_pos;
  int   size_reg;
  bin_t bins_due [$];
  int   errors;
  bit   fast_phase;   // no idling on either side while set

  // cos of a Q30 angle in [0, pi/2] by a 13-term Taylor series, Q30 out
  function automatic longint cos_series(longint unsigned x);
    longint unsigned x2, term;
    longint          acc;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int i = 1; i <= 12; i++) begin
      term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
      if (i % 2) acc -= longint'(term);
      else       acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return acc;
  endfunction

  function automatic int rev_bits(int v, int nb);
    int r;
    r = 0;
    for (int i = 0; i < nb; i++) r |= ((v >> i) & 1) << (nb - 1 - i);
    return r;
  endfunction

  // Q.31 sum of products to Q.15, nearest, ties up
  function automatic longint round_q15(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic int clamp24(longint v);
    if (v > 8388607)  return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic int eff_log2();
    return (size_reg > NLOG) ? NLOG : size_reg;
  endfunction

  // in-place DIT butterflies over the first 2^lg entries
  task automatic butterfly_pass(int lg);
    int     n, a, ie, io;
    longint c, s, er, ei, orr, oi, pr, pim;
    n = 1 << lg;
    for (int h = 1; h < n; h <<= 1)
      for (int g = 0; g < n; g += 2 * h)
        for (int k = 0; k < h; k++) begin
          a = k * ((2 * NPTS) / h);
          if (a <= NPTS) begin
            c = cos_tab[a];
            s = cos_tab[NPTS - a];
          end else begin
            c = -cos_tab[2 * NPTS - a];
            s = cos_tab[a - NPTS];
          end
          ie = g + k;
          io = g + k + h;
          er = wk_re[ie]; ei = wk_im[ie];
          orr = wk_re[io]; oi = wk_im[io];
          pr  = round_q15(orr * c + oi * s);
          pim = round_q15(oi * c - orr * s);
          wk_re[ie] = clamp24(er + pr);
          wk_im[ie] = clamp24(ei + pim);
          wk_re[io] = clamp24(er - pr);
          wk_im[io] = clamp24(ei - pim);
        end
  endtask

  // take one sample; when it closes a frame and keep is set, queue all N bins
  task automatic predict_sample(logic signed [SMP_W-1:0] smp, bit keep);
    int   lg, n, p;
    bin_t b;
    lg = eff_log2();
    n  = 1 << lg;
    if (frame_pos >= n) frame_pos = 0;
    p = rev_bits(frame_pos, lg) & (NPTS - 1);
    wk_re[p] = int'(smp);
    wk_im[p] = 0;
    frame_pos++;
    if (frame_pos < n) return;
    frame_pos = 0;
    butterfly_pass(lg);
    if (!keep) return;
    for (int i = 0; i < n; i++) begin
      b.re = wk_re[i];
      b.im = wk_im[i];
      b.last = (i == n - 1);
      bins_due.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; each send task returns
  // at a falling edge with valid still high so back-to-back beats work.
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (fast_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(logic signed [SMP_W-1:0] smp, bit typed, int re);
    int   gap;
    bin_t b;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // beat taken at this edge
    predict_sample(smp, !typed);
    if (typed) begin
      b.re = re; b.im = 0; b.last = 1'b1;
      bins_due.push_back(b);
    end
    @(negedge clk);
  endtask

  // hold off until every bin is back, then let the unit settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (bins_due.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // size write; only issued when the unit is idle
  task automatic write_size(logic [CFG_W-1:0] sz);
    in_ch.valid    <= 1'b0;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.size_log2 <= sz;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    size_reg  = sz;
    frame_pos = 0;   // a write drops any partial frame
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    return SMP_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, compare every bin beat in order.
  // ---------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("bin check failed: %s got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (pick_gap() == 0);
  end

  always @(posedge clk) begin
    bin_t b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (bins_due.size() == 0) begin
        report("unexpected bin, real", int'(out_ch.bin_real), 0);
      end else begin
        b = bins_due.pop_front();
        if (int'(out_ch.bin_real) != b.re) report("bin_real", int'(out_ch.bin_real), b.re);
        if (int'(out_ch.bin_imag) != b.im) report("bin_imag", int'(out_ch.bin_imag), b.im);
        if (out_ch.last != b.last) report("last", int'(out_ch.last), int'(b.last));
      end
    end
  end

  // watchdog: cycles with no beat on any channel
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("radix2_fft_real_input_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Directed table: one-point pass-through with bins typed in, tiny sizes,
  // size above the maximum, and a partial frame dropped by a size write.
  // ---------------------------------------------------------------------
  row_t plan [$] = '{
    '{1, 3'd0, 16'sh0000, 0, 0},
    '{0, 3'd0, 16'sh7fff, 1, 32767},
    '{0, 3'd0, 16'sh8000, 1, -32768},
    '{0, 3'd0, 16'sh0000, 1, 0},
    '{0, 3'd0, 16'sh0001, 1, 1},
    '{1, 3'd1, 16'sh0000, 0, 0},
    '{0, 3'd1, 16'sh7fff, 0, 0},
    '{0, 3'd1, 16'sh7fff, 0, 0},
    '{0, 3'd1, 16'sh8000, 0, 0},
    '{0, 3'd1, 16'sh7fff, 0, 0},
    '{1, 3'd2, 16'sh0000, 0, 0},
    '{0, 3'd2, 16'sh7fff, 0, 0},
    '{0, 3'd2, 16'sh8000, 0, 0},
    '{0, 3'd2, 16'sh7fff, 0, 0},
    '{0, 3'd2, 16'sh8000, 0, 0},
    '{1, 3'd7, 16'sh0000, 0, 0},   // above the max: runs as 64 points
    '{0, 3'd7, 16'sh1234, 0, 0},
    '{0, 3'd7, 16'shedcb, 0, 0},
    '{0, 3'd7, 16'sh5555, 0, 0},
    '{1, 3'd3, 16'sh0000, 0, 0},   // drops the three samples above
    '{0, 3'd3, 16'sh7fff, 0, 0},
    '{0, 3'd3, 16'sh0000, 0, 0},
    '{0, 3'd3, 16'sh8000, 0, 0},
    '{0, 3'd3, 16'shaaaa, 0, 0},
    '{0, 3'd3, 16'sh5555, 0, 0},
    '{0, 3'd3, 16'sh0f0f, 0, 0},
    '{0, 3'd3, 16'shf0f0, 0, 0},
    '{0, 3'd3, 16'sh3333, 0, 0}
  };

  initial begin
    int sent, lg, n, frames, sz;
    longint unsigned th;

    // twiddle ROM, Q2.16, quarter wave
    for (int i = 0; i <= NPTS; i++) begin
      th = (PI_Q30 * longint'(i) + NPTS) / (2 * NPTS);
      cos_tab[i] = int'((cos_series(th) + 8192) >>> 14);
    end
    for (int i = 0; i < NPTS; i++) begin
      wk_re[i] = 0;
      wk_im[i] = 0;
    end
    frame_pos  = 0;
    size_reg   = int'(SIZE_RESET);
    errors     = 0;
    fast_phase = 1'b0;

    in_ch.valid      <= 1'b0;
    in_ch.sample     <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.size_log2 <= SIZE_RESET;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part; size writes only after the unit has gone quiet
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_size(plan[i].size);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].re);
      end
    end
    drain();

    // random phases: mostly small sizes, whole frames, now and then a
    // partial frame left behind for the next size write to drop
    sent = 0;
    while (sent < RAND_ITEMS) begin
      sz = $urandom_range(0, 9);
      if (sz < 4)      sz = $urandom_range(0, 3);
      else if (sz < 8) sz = $urandom_range(4, 5);
      else             sz = $urandom_range(6, 7);
      fast_phase = ($urandom_range(0, 3) == 0);
      write_size(CFG_W'(sz));
      lg = (sz > NLOG) ? NLOG : sz;
      n  = 1 << lg;
      frames = (lg >= 5) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < frames * n; f++) begin
        send_sample(rand_sample(), 1'b0, 0);
        sent++;
      end
      if (n > 1 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, n - 1)) send_sample(rand_sample(), 1'b0, 0);
      drain();
    end

    if (errors == 0) begin
      $display("radix2_fft_real_input_unit: match");
    end else begin
      $display("radix2_fft_real_input_unit: mismatch");
    end
    $finish;
  end

endmodule
